>>> hw/rtl/pnm_pkg.sv
package pnm_pkg;

   // Parser phases
   typedef enum logic [3:0] {
      PH_WAIT_P     = 4'd0,
      PH_WAIT_DIGIT = 4'd1,
      PH_WIDTH      = 4'd2,
      PH_HEIGHT     = 4'd3,
      PH_MAXVAL     = 4'd4,
      PH_DATA       = 4'd5,
      PH_DONE       = 4'd6,
      PH_ERROR      = 4'd7
   } phase_type;

   // Image formats
   localparam logic [1:0] FMT_BITMAP = 2'd0;
   localparam logic [1:0] FMT_GRAY   = 2'd1;
   localparam logic [1:0] FMT_COLOR  = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Characters
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_2     = 8'h32;
   localparam logic [7:0] CH_3     = 8'h33;
   localparam logic [7:0] CH_4     = 8'h34;
   localparam logic [7:0] CH_5     = 8'h35;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam int unsigned LEVEL_MAX    = 255;
   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned QUEUE_DEPTH  = 4;

   // One queued run: the results that one request causes
   typedef struct packed {
      logic [3:0]  cnt;      // sample results, 0 to 8
      logic        hdr;      // header result follows the samples
      logic        err;      // error result closes the run
      logic        bits;     // samples are the bits of value, MSB first
      logic        last;     // final sample of the run ends the image
      logic [7:0]  value;
      logic [1:0]  ch;
      logic [1:0]  format;
      logic        is_raw;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  maxval;
   } run_type;

   function automatic logic [15:0] sat16(logic [31:0] v);
      sat16 = (v > 32'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [7:0] clamp8(logic [31:0] v);
      clamp8 = (v > LEVEL_MAX) ? 8'hFF : v[7:0];
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic is_numeric(phase_type ph, logic raw, logic [1:0] fmt);
      is_numeric = (ph == PH_WIDTH) || (ph == PH_HEIGHT) || (ph == PH_MAXVAL) ||
                   ((ph == PH_DATA) && !raw && (fmt != FMT_BITMAP));
   endfunction

endpackage

>>> hw/rtl/pnm_if.sv
interface pnm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;
   logic       end_of_file;

   modport source (output valid, data_byte, start_of_file, end_of_file, input ready);
   modport sink   (input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

interface pnm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  format;
   logic        is_raw;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic [7:0]  max_value;
   logic [7:0]  sample;
   logic [15:0] row_index;
   logic [15:0] column_index;
   logic [1:0]  channel;
   logic        last_of_image;
   logic        last_of_run;

   modport source (output valid, kind, format, is_raw, image_width, image_height,
                   max_value, sample, row_index, column_index, channel,
                   last_of_image, last_of_run, input ready);
   modport sink   (input valid, kind, format, is_raw, image_width, image_height,
                   max_value, sample, row_index, column_index, channel,
                   last_of_image, last_of_run, output ready);
endinterface

>>> hw/rtl/pnm_front.sv
module pnm_front #(
   parameter int DIM_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   pnm_req_if.sink               req_ch,
   input  logic                  q_ready,
   output logic                  push,
   output pnm_pkg::run_type      run,
   output logic [DIM_BITS-1:0]   run_row,
   output logic [DIM_BITS-1:0]   run_col
);

   localparam logic [DIM_BITS-1:0] DimMax = '1;

   pnm_pkg::phase_type  ph_ff, ph_in;
   logic [1:0]          kind_ff, kind_in;
   logic                raw_ff, raw_in;
   logic [DIM_BITS-1:0] acc_ff, acc_in;
   logic                dseen_ff, dseen_in;
   logic                cmt_ff, cmt_in;
   logic [DIM_BITS-1:0] wid_ff, wid_in;
   logic [DIM_BITS-1:0] hgt_ff, hgt_in;
   logic [7:0]          mxv_ff, mxv_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [1:0]          chn_ff, chn_in;

   logic                accept;
   logic [7:0]          c;
   logic                s_req, s_bits, s_last, hdr, err, fin, mid_ok;
   logic [7:0]          s_val;
   logic [3:0]          s_n;
   logic [DIM_BITS-1:0] s_row, s_col;
   logic [1:0]          s_ch;
   logic [DIM_BITS+3:0] acc_next;
   logic [DIM_BITS-1:0] rem, num;
   logic [DIM_BITS:0]   col_sum;
   logic                row_end, col_end, ch_end;

   assign accept       = req_ch.valid && q_ready;
   assign req_ch.ready = q_ready;
   assign c            = req_ch.data_byte;

   // Parse one request: byte path, number finish, sample run, end of file
   always_comb begin
      ph_in    = ph_ff;
      kind_in  = kind_ff;
      raw_in   = raw_ff;
      acc_in   = acc_ff;
      dseen_in = dseen_ff;
      cmt_in   = cmt_ff;
      wid_in   = wid_ff;
      hgt_in   = hgt_ff;
      mxv_in   = mxv_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      chn_in   = chn_ff;
      s_req    = 1'b0;
      s_bits   = 1'b0;
      s_last   = 1'b0;
      s_val    = '0;
      s_n      = 4'd1;
      s_row    = '0;
      s_col    = '0;
      s_ch     = '0;
      hdr      = 1'b0;
      err      = 1'b0;
      fin      = 1'b0;
      mid_ok   = 1'b0;
      acc_next = '0;
      rem      = '0;
      num      = '0;
      col_sum  = '0;
      row_end  = 1'b0;
      col_end  = 1'b0;
      ch_end   = 1'b0;

      // restart on a new file
      if (req_ch.start_of_file) begin
         ph_in    = pnm_pkg::PH_WAIT_P;
         kind_in  = pnm_pkg::FMT_BITMAP;
         raw_in   = 1'b0;
         acc_in   = '0;
         dseen_in = 1'b0;
         cmt_in   = 1'b0;
         wid_in   = '0;
         hgt_in   = '0;
         mxv_in   = '0;
         row_in   = '0;
         col_in   = '0;
         chn_in   = '0;
      end

      if (ph_in != pnm_pkg::PH_DONE && ph_in != pnm_pkg::PH_ERROR) begin
         // classify the byte
         if (cmt_in) begin
            if (c == pnm_pkg::CH_LF || c == pnm_pkg::CH_CR) begin
               cmt_in = 1'b0;
            end
         end else begin
            case (ph_in)
               pnm_pkg::PH_WAIT_P: begin
                  if (c == pnm_pkg::CH_P) begin
                     ph_in = pnm_pkg::PH_WAIT_DIGIT;
                  end else begin
                     err = 1'b1;
                  end
               end
               pnm_pkg::PH_WAIT_DIGIT: begin
                  if (c >= pnm_pkg::CH_1 && c <= pnm_pkg::CH_6) begin
                     if (c == pnm_pkg::CH_1 || c == pnm_pkg::CH_4) begin
                        kind_in = pnm_pkg::FMT_BITMAP;
                     end else if (c == pnm_pkg::CH_2 || c == pnm_pkg::CH_5) begin
                        kind_in = pnm_pkg::FMT_GRAY;
                     end else begin
                        kind_in = pnm_pkg::FMT_COLOR;
                     end
                     raw_in   = (c >= pnm_pkg::CH_4);
                     acc_in   = '0;
                     dseen_in = 1'b0;
                     ph_in    = pnm_pkg::PH_WIDTH;
                  end else begin
                     err = 1'b1;
                  end
               end
               default: begin
                  if (pnm_pkg::is_numeric(ph_in, raw_in, kind_in)) begin
                     if (c >= pnm_pkg::CH_0 && c <= pnm_pkg::CH_9) begin
                        acc_next = {acc_in, 3'b000} + {2'b00, acc_in, 1'b0} +
                                   (DIM_BITS+4)'(c - pnm_pkg::CH_0);
                        acc_in   = (acc_next > {4'b0000, DimMax}) ?
                                   DimMax : acc_next[DIM_BITS-1:0];
                        dseen_in = 1'b1;
                     end else if (!dseen_in) begin
                        if (c == pnm_pkg::CH_HASH) begin
                           cmt_in = 1'b1;
                        end else if (!pnm_pkg::is_blank(c)) begin
                           err = 1'b1;
                        end
                     end else begin
                        if (c == pnm_pkg::CH_HASH) begin
                           cmt_in = 1'b1;
                        end
                        fin = 1'b1;
                     end
                  end else if (raw_in && kind_in == pnm_pkg::FMT_BITMAP) begin
                     rem    = wid_in - col_in;
                     s_req  = 1'b1;
                     s_bits = 1'b1;
                     s_val  = c;
                     s_n    = (rem > DIM_BITS'(pnm_pkg::BITS_PER_BYTE)) ?
                              4'(pnm_pkg::BITS_PER_BYTE) : rem[3:0];
                  end else if (raw_in) begin
                     s_req = 1'b1;
                     s_val = c;
                  end else if (c == pnm_pkg::CH_0 || c == pnm_pkg::CH_1) begin
                     s_req = 1'b1;
                     s_val = {7'b0, c[0]};
                  end else if (!pnm_pkg::is_blank(c)) begin
                     err = 1'b1;
                  end
               end
            endcase
         end

         // raise a format error
         if (err) begin
            ph_in    = pnm_pkg::PH_ERROR;
            cmt_in   = 1'b0;
            dseen_in = 1'b0;
         end

         // end of file finishes a pending number
         mid_ok = (ph_in != pnm_pkg::PH_DONE) && (ph_in != pnm_pkg::PH_ERROR);
         if (!fin && req_ch.end_of_file && mid_ok && dseen_in &&
             pnm_pkg::is_numeric(ph_in, raw_in, kind_in)) begin
            fin = 1'b1;
         end

         // store a finished number
         if (fin) begin
            num      = acc_in;
            acc_in   = '0;
            dseen_in = 1'b0;
            case (ph_in)
               pnm_pkg::PH_WIDTH: begin
                  wid_in = num;
                  ph_in  = pnm_pkg::PH_HEIGHT;
               end
               pnm_pkg::PH_HEIGHT: begin
                  hgt_in = num;
                  if (kind_in == pnm_pkg::FMT_BITMAP) begin
                     mxv_in = 8'd1;
                     hdr    = 1'b1;
                  end else begin
                     ph_in = pnm_pkg::PH_MAXVAL;
                  end
               end
               pnm_pkg::PH_MAXVAL: begin
                  mxv_in = pnm_pkg::clamp8(32'(num));
                  hdr    = 1'b1;
               end
               pnm_pkg::PH_DATA: begin
                  s_req = 1'b1;
                  s_val = pnm_pkg::clamp8(32'(num));
               end
               default: begin
               end
            endcase
            if (hdr) begin
               row_in = '0;
               col_in = '0;
               chn_in = '0;
               ph_in  = (wid_in == '0 || hgt_in == '0) ?
                        pnm_pkg::PH_DONE : pnm_pkg::PH_DATA;
            end
         end

         // advance the sample position over the run
         if (s_req) begin
            s_row   = row_in;
            s_col   = col_in;
            s_ch    = chn_in;
            ch_end  = (kind_in == pnm_pkg::FMT_COLOR) ? (chn_in >= 2'd2) : 1'b1;
            col_sum = {1'b0, col_in} + (DIM_BITS+1)'(s_n);
            col_end = col_sum >= {1'b0, wid_in};
            row_end = ({1'b0, row_in} + 1'b1) >= {1'b0, hgt_in};
            s_last  = row_end && col_end && ch_end;
            if (s_last) begin
               ph_in = pnm_pkg::PH_DONE;
            end else if (ch_end) begin
               chn_in = '0;
               if (col_end) begin
                  col_in = '0;
                  row_in = row_in + 1'b1;
               end else begin
                  col_in = col_sum[DIM_BITS-1:0];
               end
            end else begin
               chn_in = chn_in + 2'd1;
            end
         end

         // flag truncation
         if (req_ch.end_of_file && mid_ok && ph_in != pnm_pkg::PH_DONE) begin
            ph_in    = pnm_pkg::PH_ERROR;
            cmt_in   = 1'b0;
            dseen_in = 1'b0;
            err      = 1'b1;
         end
      end
   end

   // Build the queue entry
   always_comb begin
      run.cnt    = s_req ? s_n : 4'd0;
      run.hdr    = hdr;
      run.err    = err;
      run.bits   = s_bits;
      run.last   = s_last;
      run.value  = s_val;
      run.ch     = s_ch;
      run.format = kind_in;
      run.is_raw = raw_in;
      run.width  = pnm_pkg::sat16(32'(wid_in));
      run.height = pnm_pkg::sat16(32'(hgt_in));
      run.maxval = mxv_in;
   end

   assign run_row = s_row;
   assign run_col = s_col;
   assign push    = accept && (s_req || hdr || err);

   // Hold parser state between requests
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff    <= pnm_pkg::PH_WAIT_P;
         kind_ff  <= pnm_pkg::FMT_BITMAP;
         raw_ff   <= 1'b0;
         acc_ff   <= '0;
         dseen_ff <= 1'b0;
         cmt_ff   <= 1'b0;
         wid_ff   <= '0;
         hgt_ff   <= '0;
         mxv_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         chn_ff   <= '0;
      end else if (accept) begin
         ph_ff    <= ph_in;
         kind_ff  <= kind_in;
         raw_ff   <= raw_in;
         acc_ff   <= acc_in;
         dseen_ff <= dseen_in;
         cmt_ff   <= cmt_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         mxv_ff   <= mxv_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         chn_ff   <= chn_in;
      end
   end

   // A run that ends in an error never closes the image
   a_err_not_last: assert property (@(posedge clock) disable iff (reset)
      push && run.err |-> !run.last)
      else $error("error run also marks the image end");

   // A stopped parser stays silent until the next file starts
   a_quiet_after_stop: assert property (@(posedge clock) disable iff (reset)
      accept && !req_ch.start_of_file &&
      (ph_ff == pnm_pkg::PH_ERROR || ph_ff == pnm_pkg::PH_DONE) |-> !push)
      else $error("results after the parser stopped");

endmodule

>>> hw/rtl/pnm_queue.sv
module pnm_queue #(
   parameter int DIM_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pnm_pkg::run_type      push_run,
   input  logic [DIM_BITS-1:0]   push_row,
   input  logic [DIM_BITS-1:0]   push_col,
   output logic                  q_ready,
   output logic                  q_valid,
   input  logic                  pop,
   output pnm_pkg::run_type      head_run,
   output logic [DIM_BITS-1:0]   head_row,
   output logic [DIM_BITS-1:0]   head_col
);

   localparam int Depth   = pnm_pkg::QUEUE_DEPTH;
   localparam int PtrBits = $clog2(Depth);
   localparam int CntBits = $clog2(Depth + 1);

   pnm_pkg::run_type    run_ff [Depth];
   logic [DIM_BITS-1:0] row_ff [Depth];
   logic [DIM_BITS-1:0] col_ff [Depth];
   logic [PtrBits-1:0]  wr_ff, wr_in;
   logic [PtrBits-1:0]  rd_ff, rd_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign q_ready  = (count_ff != CntBits'(Depth));
   assign q_valid  = (count_ff != '0);
   assign do_push  = push && q_ready;
   assign do_pop   = pop && q_valid;
   assign head_run = run_ff[rd_ff];
   assign head_row = row_ff[rd_ff];
   assign head_col = col_ff[rd_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_in    = do_push ? PtrBits'(wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? PtrBits'(rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + CntBits'(do_push) - CntBits'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         run_ff[wr_ff] <= push_run;
         row_ff[wr_ff] <= push_row;
         col_ff[wr_ff] <= push_col;
      end
   end

   // The front only writes while there is room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> q_ready)
      else $error("run queue overflow");

   // The back only takes entries that exist
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("run queue underflow");

endmodule

>>> hw/rtl/pnm_back.sv
module pnm_back #(
   parameter int DIM_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  pnm_pkg::run_type      run,
   input  logic [DIM_BITS-1:0]   run_row,
   input  logic [DIM_BITS-1:0]   run_col,
   output logic                  pop,
   pnm_rsp_if.source             rsp_ch
);

   logic [2:0]          idx_ff, idx_in;
   logic                vld_ff, vld_in;
   logic [1:0]          kind_ff, kind_in;
   logic [1:0]          fmt_ff;
   logic                raw_ff;
   logic [15:0]         wid_ff, hgt_ff;
   logic [7:0]          mxv_ff;
   logic [7:0]          smp_ff, smp_in;
   logic [15:0]         row_ff, row_in;
   logic [15:0]         col_ff, col_in;
   logic [1:0]          chn_ff, chn_in;
   logic                loi_ff, loi_in;
   logic                lor_ff, lor_in;

   logic [3:0]          shown, tot;
   logic                load, last_res, is_smp;
   logic [DIM_BITS:0]   col_pos;

   // Size the run: an error takes the place of an eighth sample
   assign shown    = (run.err && run.cnt == 4'd8) ? 4'd7 : run.cnt;
   assign tot      = shown + {3'b000, run.hdr} + {3'b000, run.err};
   assign load     = q_valid && (!vld_ff || rsp_ch.ready);
   assign last_res = ({1'b0, idx_ff} == (tot - 4'd1));
   assign pop      = load && last_res;
   assign is_smp   = ({1'b0, idx_ff} < shown);
   assign col_pos  = {1'b0, run_col} + (DIM_BITS+1)'(idx_ff);

   // Form the next result of the head run
   always_comb begin
      kind_in = pnm_pkg::KIND_ERROR;
      smp_in  = '0;
      row_in  = '0;
      col_in  = '0;
      chn_in  = '0;
      loi_in  = 1'b0;
      lor_in  = last_res;
      if (is_smp) begin
         kind_in = pnm_pkg::KIND_SAMPLE;
         smp_in  = run.bits ? {7'b0, run.value[~idx_ff]} : run.value;
         row_in  = pnm_pkg::sat16(32'(run_row));
         col_in  = pnm_pkg::sat16(32'(col_pos));
         chn_in  = run.ch;
         loi_in  = run.last && ({1'b0, idx_ff} == (run.cnt - 4'd1));
      end else if (run.hdr && ({1'b0, idx_ff} == shown)) begin
         // header sits right after the samples, an error follows it
         kind_in = pnm_pkg::KIND_HEADER;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = last_res ? 3'd0 : idx_ff + 3'd1;
      end
      vld_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : vld_ff);
   end

   // Hold the control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         fmt_ff  <= run.format;
         raw_ff  <= run.is_raw;
         wid_ff  <= run.width;
         hgt_ff  <= run.height;
         mxv_ff  <= run.maxval;
         smp_ff  <= smp_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         chn_ff  <= chn_in;
         loi_ff  <= loi_in;
         lor_ff  <= lor_in;
      end
   end

   assign rsp_ch.valid         = vld_ff;
   assign rsp_ch.kind          = kind_ff;
   assign rsp_ch.format        = fmt_ff;
   assign rsp_ch.is_raw        = raw_ff;
   assign rsp_ch.image_width   = wid_ff;
   assign rsp_ch.image_height  = hgt_ff;
   assign rsp_ch.max_value     = mxv_ff;
   assign rsp_ch.sample        = smp_ff;
   assign rsp_ch.row_index     = row_ff;
   assign rsp_ch.column_index  = col_ff;
   assign rsp_ch.channel       = chn_ff;
   assign rsp_ch.last_of_image = loi_ff;
   assign rsp_ch.last_of_run   = lor_ff;

   // The run index never walks past the end of the head run
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> ({1'b0, idx_ff} < tot))
      else $error("run index beyond run length");

   // The image end is always the final result of its request
   a_image_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      vld_ff && loi_ff |-> lor_ff)
      else $error("image end not at the end of its run");

endmodule

>>> hw/rtl/pnm_byte_stream_decoder.sv
// PNM byte-stream decoder. Takes a PBM, PGM or PPM file (P1 to P6) one byte per request, checks
// the magic, parses width, height and maxval (blanks and '#' comments skipped, maxval clamped
// to 255) and returns a header result, then one result per sample with its row, column and
// channel, or an error result on malformed or truncated input. start_of_file restarts the
// parser; end_of_file completes a pending number. A request is accepted every cycle as long
// as each causes at most one result and rsp_ch.ready stays high; the output port delivers
// one result per cycle, so a raw bitmap byte (up to eight samples) yields one result per
// sample. A four-entry run queue between the byte parser and the result sequencer absorbs
// these bursts; input stalls only when it fills. Each result passes through a run queue
// entry and then the output register. DIM_BITS sets the internal width of the dimension
// and position counters; reported dimensions and positions saturate at 65535.
module pnm_byte_stream_decoder #(
   parameter int DIM_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   pnm_req_if.sink    req_ch,
   pnm_rsp_if.source  rsp_ch
);

   logic                push, q_ready, q_valid, pop;
   pnm_pkg::run_type    push_run, head_run;
   logic [DIM_BITS-1:0] push_row, push_col, head_row, head_col;

   pnm_front #(.DIM_BITS(DIM_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_ready (q_ready),
      .push    (push),
      .run     (push_run),
      .run_row (push_row),
      .run_col (push_col)
   );

   pnm_queue #(.DIM_BITS(DIM_BITS)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .push_row (push_row),
      .push_col (push_col),
      .q_ready  (q_ready),
      .q_valid  (q_valid),
      .pop      (pop),
      .head_run (head_run),
      .head_row (head_row),
      .head_col (head_col)
   );

   pnm_back #(.DIM_BITS(DIM_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .run     (head_run),
      .run_row (head_row),
      .run_col (head_col),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
